// ===== hdl/lea_pkg.sv =====
// Package: LEA constants, key-size codes and helper functions.
`timescale 1ns / 1ps
`default_nettype none
package lea_pkg;

  typedef enum logic [1:0] {
    KS_128 = 2'd0,
    KS_192 = 2'd1,
    KS_256 = 2'd2,
    KS_256X = 2'd3
  } key_size_e;

  typedef enum logic [2:0] {
    REG_KEY_SIZE = 3'd0,
    REG_KEY_P0   = 3'd1,
    REG_KEY_P1   = 3'd2,
    REG_KEY_P2   = 3'd3,
    REG_KEY_P3   = 3'd4
  } reg_idx_e;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  typedef logic [31:0] word_t;

  function automatic word_t delta(input logic [2:0] idx);
    word_t d;
    case (idx)
      3'd0: d = 32'hc3efe9db;
      3'd1: d = 32'h44626b02;
      3'd2: d = 32'h79e27c8a;
      3'd3: d = 32'h78df30ec;
      3'd4: d = 32'h715ea49e;
      3'd5: d = 32'hc785da0a;
      3'd6: d = 32'he04ef22a;
      default: d = 32'he5c40957;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] ks_rot(input logic [2:0] j);
    logic [4:0] r;
    case (j)
      3'd0: r = 5'd1;
      3'd1: r = 5'd3;
      3'd2: r = 5'd6;
      3'd3: r = 5'd11;
      3'd4: r = 5'd13;
      default: r = 5'd17;
    endcase
    return r;
  endfunction

  function automatic word_t rol(input word_t x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lea_keysched.sv =====
// Key schedule: one round-key word per cycle through a shared add/rotate unit.
`timescale 1ns / 1ps
`default_nettype none
module lea_keysched #(
  parameter int MaxRounds = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire  [1:0]          key_size_i,
  input  wire  [5:0]          nr_i,
  input  wire  [255:0]        key_i,
  output logic                busy_o,
  output logic                we_o,
  output logic [$clog2(MaxRounds*6)-1:0] waddr_o,
  output lea_pkg::word_t      wdata_o
);
  localparam int AW = $clog2(MaxRounds*6);
  lea_pkg::word_t t_q [8];
  logic [5:0] i_q;
  logic [2:0] j_q;
  logic [2:0] k_q;
  logic [2:0] di_q;
  logic busy_q;
  logic [AW-1:0] addr_q;
  logic [2:0] nj;
  logic [2:0] tk;
  lea_pkg::word_t tn;

  assign nj = (key_size_i == lea_pkg::KS_128) ? 3'd4 : 3'd6;
  assign tk = (key_size_i == lea_pkg::KS_128 || key_size_i == lea_pkg::KS_192) ? j_q : k_q;
  assign tn = lea_pkg::rol(t_q[tk] + lea_pkg::rol(lea_pkg::delta(di_q), i_q[4:0] + {2'b0, j_q}),
                           lea_pkg::ks_rot(j_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      di_q <= '0;
      addr_q <= '0;
      for (int n = 0; n < 8; n++) t_q[n] <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      di_q <= '0;
      addr_q <= '0;
      for (int n = 0; n < 8; n++) t_q[n] <= key_i[32*n +: 32];
    end else if (busy_q) begin
      t_q[tk] <= tn;
      k_q <= k_q + 3'd1;
      if (j_q == nj - 3'd1 && key_size_i == lea_pkg::KS_128) addr_q <= addr_q + AW'(3);
      else addr_q <= addr_q + AW'(1);
      if (j_q == nj - 3'd1) begin
        j_q <= '0;
        if (i_q == nr_i - 6'd1) busy_q <= 1'b0;
        i_q <= i_q + 6'd1;
        if (key_size_i == lea_pkg::KS_128) di_q <= {1'b0, di_q[1:0] + 2'd1};
        else if (key_size_i == lea_pkg::KS_192) di_q <= (di_q == 3'd5) ? 3'd0 : di_q + 3'd1;
        else di_q <= di_q + 3'd1;
      end else begin
        j_q <= j_q + 3'd1;
      end
    end
  end

  // 128-bit layout: t0,t1,t2 at offsets 0..2, t3 at 4; offsets 3 and 5 read back offset 1
  always_comb begin
    waddr_o = addr_q;
    if (key_size_i == lea_pkg::KS_128 && j_q == 3'd3) waddr_o = addr_q + AW'(1);
  end
  assign we_o = busy_q;
  assign wdata_o = tn;
  assign busy_o = busy_q;
endmodule
`default_nettype wire

// ===== hdl/lea_round.sv =====
// Round unit: one LEA encrypt or decrypt round, all six round-key words applied at once.
`timescale 1ns / 1ps
`default_nettype none
module lea_round (
  input  wire            dec_i,
  input  lea_pkg::word_t x_i [4],
  input  lea_pkg::word_t rk_i [6],
  output lea_pkg::word_t x_o [4]
);
  lea_pkg::word_t y1, y2;
  always_comb begin
    y1 = 32'd0;
    y2 = 32'd0;
    if (dec_i == lea_pkg::CMD_ENC) begin
      x_o[0] = lea_pkg::rol((x_i[0] ^ rk_i[0]) + (x_i[1] ^ rk_i[1]), 5'd9);
      x_o[1] = lea_pkg::rol((x_i[1] ^ rk_i[2]) + (x_i[2] ^ rk_i[3]), 5'd27);
      x_o[2] = lea_pkg::rol((x_i[2] ^ rk_i[4]) + (x_i[3] ^ rk_i[5]), 5'd29);
      x_o[3] = x_i[0];
    end else begin
      y1 = (lea_pkg::rol(x_i[0], 5'd23) - (x_i[3] ^ rk_i[0])) ^ rk_i[1];
      y2 = (lea_pkg::rol(x_i[1], 5'd5) - (y1 ^ rk_i[2])) ^ rk_i[3];
      x_o[0] = x_i[3];
      x_o[1] = y1;
      x_o[2] = y2;
      x_o[3] = (lea_pkg::rol(x_i[2], 5'd3) - (y2 ^ rk_i[4])) ^ rk_i[5];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lea_block_cipher.sv =====
// Top level: LEA-128/192/256 block cipher with on-chip round-key store.
// Per round (Nr = 24/28/32): six round-key words are read one per cycle, the last word is
// loaded, then the round is applied.
// The first block after reset or a key write also runs the key schedule first.
// Input is not ready until the result beat is taken, so one block is in flight at a time.
// Reset (async, active low) zeroes registers but mem_q and rd_q; marks round keys stale.
`timescale 1ns / 1ps
`default_nettype none
module lea_block_cipher #(
  parameter int MAX_ROUNDS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [63:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         command_i,
  input  wire  [31:0] in_word0_i,
  input  wire  [31:0] in_word1_i,
  input  wire  [31:0] in_word2_i,
  input  wire  [31:0] in_word3_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] out_word0_o,
  output logic [31:0] out_word1_o,
  output logic [31:0] out_word2_o,
  output logic [31:0] out_word3_o
);
  localparam int AW = $clog2(MAX_ROUNDS*6);
  localparam int RW = $clog2(MAX_ROUNDS+1);

  typedef enum logic [2:0] {S_IDLE, S_KEYS, S_FETCH, S_ROUND, S_OUT} state_e;
  state_e state_q;

  logic [1:0] key_size_q;
  logic [255:0] key_q;
  logic keys_ok_q;
  logic cmd_q;
  lea_pkg::word_t x_q [4];
  lea_pkg::word_t x_nx [4];
  lea_pkg::word_t rk_q [6];
  lea_pkg::word_t mem_q [MAX_ROUNDS*6];
  logic [RW-1:0] r_q;
  logic [2:0] w_q;
  logic [5:0] nr;
  logic [RW-1:0] nr_c;
  logic ks_start, ks_busy, ks_we;
  logic [AW-1:0] ks_addr, rd_addr;
  lea_pkg::word_t ks_data, rd_q;
  logic rd_pend_q;
  logic [2:0] rd_w_q;
  logic [RW-1:0] r_eff;
  logic [2:0] w_rd;

  always_comb begin
    case (key_size_q)
      lea_pkg::KS_128: nr = 6'd24;
      lea_pkg::KS_192: nr = 6'd28;
      default: nr = 6'd32;
    endcase
    if (int'(nr) > MAX_ROUNDS) nr = 6'(MAX_ROUNDS);
    nr_c = RW'(nr);
  end

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign ks_start = (state_q == S_IDLE) && in_valid_i && in_ready_o && !keys_ok_q;

  lea_keysched #(.MaxRounds(MAX_ROUNDS)) u_ks (
    .clk_i, .rst_ni, .start_i(ks_start), .key_size_i(key_size_q), .nr_i(nr),
    .key_i(key_q), .busy_o(ks_busy), .we_o(ks_we), .waddr_o(ks_addr),
    .wdata_o(ks_data)
  );

  lea_round u_rnd (.dec_i(cmd_q), .x_i(x_q), .rk_i(rk_q), .x_o(x_nx));

  // round key row: six words read one per cycle
  assign r_eff = (cmd_q == lea_pkg::CMD_ENC) ? r_q : nr_c - RW'(1) - r_q;
  assign w_rd = (key_size_q == lea_pkg::KS_128 && (w_q inside {3'd3, 3'd5})) ? 3'd1 : w_q;
  assign rd_addr = AW'(r_eff * 6 + w_rd);

  always_ff @(posedge clk_i) begin
    if (ks_we) mem_q[ks_addr] <= ks_data;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      key_size_q <= '0;
      key_q <= '0;
      keys_ok_q <= 1'b0;
      cmd_q <= lea_pkg::CMD_ENC;
      x_q <= '{default: '0};
      rk_q <= '{default: '0};
      r_q <= '0;
      w_q <= '0;
      rd_pend_q <= 1'b0;
      rd_w_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == S_FETCH);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          lea_pkg::REG_KEY_SIZE: begin key_size_q <= cfg_data_i[1:0]; keys_ok_q <= 1'b0; end
          lea_pkg::REG_KEY_P0: begin key_q[63:0] <= cfg_data_i; keys_ok_q <= 1'b0; end
          lea_pkg::REG_KEY_P1: begin key_q[127:64] <= cfg_data_i; keys_ok_q <= 1'b0; end
          lea_pkg::REG_KEY_P2: begin key_q[191:128] <= cfg_data_i; keys_ok_q <= 1'b0; end
          lea_pkg::REG_KEY_P3: begin key_q[255:192] <= cfg_data_i; keys_ok_q <= 1'b0; end
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            cmd_q <= command_i;
            x_q[0] <= in_word0_i;
            x_q[1] <= in_word1_i;
            x_q[2] <= in_word2_i;
            x_q[3] <= in_word3_i;
            r_q <= '0;
            w_q <= '0;
            state_q <= keys_ok_q ? S_FETCH : S_KEYS;
          end
        end
        S_KEYS: begin
          if (!ks_busy && !ks_start) begin
            keys_ok_q <= 1'b1;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          rd_w_q <= w_q;
          if (rd_pend_q) rk_q[rd_w_q] <= rd_q;
          if (w_q == 3'd5) begin
            w_q <= '0;
            state_q <= S_ROUND;
          end else begin
            w_q <= w_q + 3'd1;
          end
        end
        S_ROUND: begin
          if (rd_pend_q) rk_q[rd_w_q] <= rd_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // round applied here, rk_q complete
          if (out_valid_o) begin
            if (out_ready_i) begin
              out_valid_o <= 1'b0;
              state_q <= S_IDLE;
            end
          end else begin
            x_q <= x_nx;
            if (r_q == nr_c - RW'(1)) begin
              out_valid_o <= 1'b1;
            end else begin
              r_q <= r_q + RW'(1);
              state_q <= S_FETCH;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_word0_o = x_q[0];
  assign out_word1_o = x_q[1];
  assign out_word2_o = x_q[2];
  assign out_word3_o = x_q[3];
endmodule
`default_nettype wire

// ===== hdl/lea_checker.sv =====
// Port checker for the LEA block cipher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lea_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [31:0] out_word0_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word0_o))
    else $error("result beat dropped");
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("block not busy after input");
endmodule
bind lea_block_cipher lea_checker u_chk (.*);
`default_nettype wire
